// ===== rtl/stable_matching_solver_assert.svh =====
// ---------------------------------------------------------------------------
// Stable matching solver assertion macros
// Implication checks that can be compiled out by defining ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef STABLE_MATCHING_SOLVER_ASSERT_SVH
`define STABLE_MATCHING_SOLVER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SMS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stable_matching_solver: assertion failed");
// Next-cycle implication.
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stable_matching_solver: assertion failed");
`else
`define SMS_ASSERT_IMP(label, clk, rst, ante, cons)
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/sms_pkg.sv =====
// ---------------------------------------------------------------------------
// sms_pkg
// Shared widths, command codes and beat types of the stable matching solver.
// ---------------------------------------------------------------------------
package sms_pkg;

  localparam int MAX_PART  = 64;
  localparam int IDX_W     = $clog2(MAX_PART);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int TBL_DEPTH = MAX_PART * MAX_PART;

  typedef enum logic [1:0] {
    CMD_PREF  = 2'd0,
    CMD_RANK  = 2'd1,
    CMD_SOLVE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] person;
    logic [IDX_W-1:0] position;
    logic [IDX_W-1:0] partner;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] proposer;
    logic [IDX_W-1:0] acceptor;
    logic             matched;
    logic             last;
  } out_item_t;

  // Updates from the sequencer to the matching state
  typedef struct packed {
    logic             nc_we;
    logic [CNT_W-1:0] nc_data;
    logic             take;
    logic             drop;
  } mate_upd_t;

endpackage

// ===== rtl/sms_tables.sv =====
// ---------------------------------------------------------------------------
// sms_tables
// Proposer preference memory and acceptor rank memory, registered reads.
// ---------------------------------------------------------------------------
module sms_tables import sms_pkg::*; (
  input  logic              clk,
  input  logic              pref_we,
  input  logic              rank_we,
  input  in_item_t          item,
  input  logic [ADDR_W-1:0] pref_raddr,
  input  logic [ADDR_W-1:0] rank_raddr_a,
  input  logic [ADDR_W-1:0] rank_raddr_b,
  output logic [IDX_W-1:0]  pref_q,
  output logic [IDX_W-1:0]  rank_qa,
  output logic [IDX_W-1:0]  rank_qb
);

  logic [IDX_W-1:0] pref_mem [TBL_DEPTH];
  logic [IDX_W-1:0] rank_mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (pref_we) begin
      pref_mem[{item.person, item.position}] <= item.partner;
    end
    pref_q <= pref_mem[pref_raddr];
  end

  // Rank is indexed by acceptor and proposer; lower is better
  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[{item.person, item.partner}] <= item.position;
    end
    rank_qa <= rank_mem[rank_raddr_a];
    rank_qb <= rank_mem[rank_raddr_b];
  end

endmodule

// ===== rtl/sms_mates.sv =====
// ---------------------------------------------------------------------------
// sms_mates
// Matching state: held flags, mate memories and next-choice memory.
// ---------------------------------------------------------------------------
module sms_mates import sms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic [IDX_W-1:0] p_idx,
  input  logic [IDX_W-1:0] a_idx,
  input  logic [IDX_W-1:0] drop_idx,
  input  mate_upd_t        upd,
  output logic [CNT_W-1:0] nc_value,
  output logic [IDX_W-1:0] pmate_q,
  output logic [IDX_W-1:0] amate_q,
  output logic             p_held,
  output logic             a_held
);

  logic [MAX_PART-1:0] pheld;
  logic [MAX_PART-1:0] aheld;
  logic [MAX_PART-1:0] ncv;
  logic                ncv_q;
  logic [CNT_W-1:0]    nc_q;

  logic [CNT_W-1:0] nc_mem    [MAX_PART];
  logic [IDX_W-1:0] pmate_mem [MAX_PART];
  logic [IDX_W-1:0] amate_mem [MAX_PART];

  // Valid and held flags; clearing these empties the matching at once
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      pheld <= '0;
      aheld <= '0;
      ncv   <= '0;
    end else begin
      if (upd.nc_we) begin
        ncv[p_idx] <= 1'b1;
      end
      if (upd.drop) begin
        pheld[drop_idx] <= 1'b0;
      end
      if (upd.take) begin
        pheld[p_idx] <= 1'b1;
        aheld[a_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.nc_we) begin
      nc_mem[p_idx] <= upd.nc_data;
    end
    if (upd.take) begin
      pmate_mem[p_idx] <= a_idx;
      amate_mem[a_idx] <= p_idx;
    end
    nc_q    <= nc_mem[p_idx];
    ncv_q   <= ncv[p_idx];
    pmate_q <= pmate_mem[p_idx];
    amate_q <= amate_mem[a_idx];
  end

  assign nc_value = ncv_q ? nc_q : '0;
  assign p_held   = pheld[p_idx];
  assign a_held   = aheld[a_idx];

endmodule

// ===== rtl/stable_matching_solver.sv =====
// ---------------------------------------------------------------------------
// stable_matching_solver
// Proposer-optimal stable matching over loaded preference and rank tables.
// ---------------------------------------------------------------------------
// A load beat is written straight into the tables and busy stays low. A solve
// beat raises busy over all proposal rounds plus a final empty round, then
// over the emission of one pair per proposer. No beat is taken while busy.
// Throughput is set by the sequencer sharing one read port per state memory.
// The receiver cannot stall: each pair shows on result for one cycle.
// Reset: idle, participants = 64, tables undefined until written.
`include "stable_matching_solver_assert.svh"

module stable_matching_solver import sms_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_data,
  output logic             strobe,
  output out_item_t        result
);

  // One-hot sequencer states
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_P_READ = 8'b0000_0010,  // next-choice read in flight
    ST_P_TEST = 8'b0000_0100,  // decide whether this proposer proposes
    ST_P_PREF = 8'b0000_1000,  // preferred acceptor arrives
    ST_P_MATE = 8'b0001_0000,  // acceptor's current mate arrives
    ST_P_RANK = 8'b0010_0000,  // both ranks arrive, compare
    ST_E_READ = 8'b0100_0000,  // mate read for emission
    ST_E_OUT  = 8'b1000_0000   // drive one result beat
  } state_t;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;     // proposer under visit or emission
  logic [IDX_W-1:0] tgt, tgt_next;     // acceptor proposed to
  logic [IDX_W-1:0] cur, cur_next;     // acceptor's mate being challenged
  logic             round_busy, round_busy_next;
  logic [CNT_W-1:0] participants;

  logic [CNT_W-1:0] n_eff;
  logic             last_idx;
  logic             advance;
  logic             clear;
  mate_upd_t        upd;

  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] pref_q, rank_qa, rank_qb;
  logic [CNT_W-1:0] nc_value;
  logic [IDX_W-1:0] pmate_q, amate_q;
  logic             p_held, a_held;
  logic             load_accept;

  // Clamp the participant count into 1..MAX_PART
  always_comb begin
    if (participants == '0) begin
      n_eff = CNT_W'(1);
    end else if (participants > CNT_W'(MAX_PART)) begin
      n_eff = CNT_W'(MAX_PART);
    end else begin
      n_eff = participants;
    end
  end

  assign last_idx    = ({1'b0, idx} + CNT_W'(1)) == n_eff;
  assign busy        = (state != ST_IDLE);
  assign cfg_ready   = ~busy;
  assign load_accept = start && !busy;

  // The acceptor address follows the preference read directly while it lands
  assign a_idx = (state == ST_P_PREF) ? pref_q : tgt;

  sms_tables u_tables (
    .clk          (clk),
    .pref_we      (load_accept && (item.cmd == CMD_PREF)),
    .rank_we      (load_accept && (item.cmd == CMD_RANK)),
    .item         (item),
    .pref_raddr   ({idx, nc_value[IDX_W-1:0]}),
    .rank_raddr_a ({tgt, amate_q}),
    .rank_raddr_b ({tgt, idx}),
    .pref_q       (pref_q),
    .rank_qa      (rank_qa),
    .rank_qb      (rank_qb)
  );

  sms_mates u_mates (
    .clk      (clk),
    .rst      (rst),
    .clear    (clear),
    .p_idx    (idx),
    .a_idx    (a_idx),
    .drop_idx (cur),
    .upd      (upd),
    .nc_value (nc_value),
    .pmate_q  (pmate_q),
    .amate_q  (amate_q),
    .p_held   (p_held),
    .a_held   (a_held)
  );

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    tgt_next        = tgt;
    cur_next        = cur;
    round_busy_next = round_busy;
    upd             = '0;
    clear           = 1'b0;
    advance         = 1'b0;
    strobe          = 1'b0;

    case (state)
      ST_IDLE: begin
        // Loads are written straight into the tables; only a solve leaves idle
        if (load_accept && (item.cmd == CMD_SOLVE)) begin
          clear           = 1'b1;
          idx_next        = '0;
          round_busy_next = 1'b0;
          state_next      = ST_P_READ;
        end
      end
      ST_P_READ: begin
        state_next = ST_P_TEST;
      end
      ST_P_TEST: begin
        // Skip a held proposer or one whose list is spent
        if (p_held || (nc_value >= n_eff)) begin
          advance = 1'b1;
        end else begin
          upd.nc_we       = 1'b1;
          upd.nc_data     = nc_value + CNT_W'(1);
          round_busy_next = 1'b1;
          state_next      = ST_P_PREF;
        end
      end
      ST_P_PREF: begin
        tgt_next   = pref_q;
        state_next = ST_P_MATE;
      end
      ST_P_MATE: begin
        // A free acceptor takes him at once
        if (!a_held) begin
          upd.take = 1'b1;
          advance  = 1'b1;
        end else begin
          cur_next   = amate_q;
          state_next = ST_P_RANK;
        end
      end
      ST_P_RANK: begin
        // Strictly better rank wins; on a tie she keeps her mate
        if (rank_qa > rank_qb) begin
          upd.drop = 1'b1;
          upd.take = 1'b1;
        end
        advance = 1'b1;
      end
      ST_E_READ: begin
        state_next = ST_E_OUT;
      end
      ST_E_OUT: begin
        strobe = 1'b1;
        if (last_idx) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = idx + IDX_W'(1);
          state_next = ST_E_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Step to the next proposer; at the end of a round either rerun or emit
    if (advance) begin
      if (last_idx) begin
        idx_next = '0;
        if (round_busy) begin
          round_busy_next = 1'b0;
          state_next      = ST_P_READ;
        end else begin
          state_next = ST_E_READ;
        end
      end else begin
        idx_next   = idx + IDX_W'(1);
        state_next = ST_P_READ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      round_busy   <= 1'b0;
      participants <= CNT_W'(MAX_PART);
    end else begin
      state      <= state_next;
      round_busy <= round_busy_next;
      if (cfg_valid && cfg_ready) begin
        participants <= cfg_data;
      end
    end
  end

  // Indices need no reset: every path sets them before use
  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    cur <= cur_next;
  end

  // Unmatched proposers report acceptor zero
  always_comb begin
    result.proposer = idx;
    result.acceptor = p_held ? pmate_q : '0;
    result.matched  = p_held;
    result.last     = last_idx;
  end

  // A solve beat always raises busy in the following cycle
  `SMS_ASSERT_NEXT(a_solve_busy, clk, rst, load_accept && (item.cmd == CMD_SOLVE), busy)
  // Pairs are spaced by a mate read, so no beat repeats back to back
  `SMS_ASSERT_NEXT(a_beat_gap, clk, rst, strobe && !result.last, !strobe)
  // The final pair returns the block to idle
  `SMS_ASSERT_NEXT(a_last_idle, clk, rst, strobe && result.last, !busy)

endmodule

// ===== test/stable_matching_solver_test.sv =====
// ---------------------------------------------------------------------------
// stable_matching_solver_test
// Self-checking bench for the stable matching solver. Loads proposer lists
// and acceptor rank tables, issues solve beats under several participant
// counts, and checks every emitted pair against a proposer-optimal matching
// worked out alongside the block.
// ---------------------------------------------------------------------------
module stable_matching_solver_test;
  import sms_pkg::*;

  localparam int         HALF_PERIOD   = 4;
  localparam int         RESET_CYCLES  = 12;
  localparam int         RANDOM_BEATS  = 320;
  localparam int         SETTLE_CYCLES = 8;
  // Allow hundreds of worst-case solves at 64 participants plus every long
  // sender gap, then several times over.
  localparam int         CYCLE_LIMIT   = 2000000;
  localparam int         NO_MATE       = MAX_PART;
  localparam int         RANK_BASE     = TBL_DEPTH;
  localparam int         CFG_TOP       = (1 << CNT_W) - 1;
  localparam logic [1:0] CMD_SPARE     = 2'd3;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic             busy;
  in_item_t         item      = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data  = '0;
  logic             strobe;
  out_item_t        result;

  // Shadow of the loaded tables, with a record of which entries hold data
  logic [IDX_W-1:0] pref_list  [TBL_DEPTH];
  logic [IDX_W-1:0] rank_of    [TBL_DEPTH];
  bit               pref_known [TBL_DEPTH];
  bit               rank_known [TBL_DEPTH];
  int               mate_of_proposer [MAX_PART];
  int               mate_of_acceptor [MAX_PART];
  int               next_pick        [MAX_PART];
  int               order            [MAX_PART];
  logic [CNT_W-1:0] participants = CNT_W'(MAX_PART);

  out_item_t        pairs_due [$];
  out_item_t        want;
  int               mismatches = 0;
  int               cycles     = 0;
  int               burst_left = 0;
  int               beats_sent = 0;

  stable_matching_solver dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .result    (result)
  );

  always #HALF_PERIOD clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Matching prediction
  // ------------------------------------------------------------------------
  function automatic int active_count();
    if (participants == 0) return 1;
    if (participants > MAX_PART) return MAX_PART;
    return int'(participants);
  endfunction

  // Run proposal rounds over the shadow tables. Return -1 when done, or the
  // first entry the rounds would read that was never loaded (rank entries
  // offset by RANK_BASE), so that it can be loaded before the solve.
  function automatic int gale_shapley(input int n);
    int p;
    int t;
    int cur;
    int slot;
    bit moved;
    for (p = 0; p < MAX_PART; p++) begin
      mate_of_proposer[p] = NO_MATE;
      mate_of_acceptor[p] = NO_MATE;
      next_pick[p]        = 0;
    end
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (p = 0; p < n; p++) begin
        if (mate_of_proposer[p] == NO_MATE && next_pick[p] < n) begin
          slot = p * MAX_PART + next_pick[p];
          if (!pref_known[slot]) return slot;
          t = int'(pref_list[slot]);
          next_pick[p]++;
          moved = 1'b1;
          cur = mate_of_acceptor[t];
          if (cur == NO_MATE) begin
            mate_of_proposer[p] = t;
            mate_of_acceptor[t] = p;
          end else begin
            if (!rank_known[t * MAX_PART + cur]) return RANK_BASE + t * MAX_PART + cur;
            if (!rank_known[t * MAX_PART + p]) return RANK_BASE + t * MAX_PART + p;
            // Strictly better rank wins; on a tie she keeps her mate
            if (rank_of[t * MAX_PART + cur] > rank_of[t * MAX_PART + p]) begin
              mate_of_proposer[cur] = NO_MATE;
              mate_of_acceptor[t]   = p;
              mate_of_proposer[p]   = t;
            end
          end
        end
      end
    end
    return -1;
  endfunction

  // Apply one accepted beat to the shadow state; queue pairs for a solve
  function automatic void absorb_beat(input in_item_t it);
    int        n;
    int        p;
    out_item_t pair;
    case (it.cmd)
      CMD_PREF: begin
        pref_list[{it.person, it.position}]  = it.partner;
        pref_known[{it.person, it.position}] = 1'b1;
      end
      CMD_RANK: begin
        rank_of[{it.person, it.partner}]    = it.position;
        rank_known[{it.person, it.partner}] = 1'b1;
      end
      CMD_SOLVE: begin
        n = active_count();
        void'(gale_shapley(n));
        for (p = 0; p < n; p++) begin
          pair.proposer = IDX_W'(p);
          pair.matched  = (mate_of_proposer[p] != NO_MATE);
          pair.acceptor = pair.matched ? IDX_W'(mate_of_proposer[p]) : '0;
          pair.last     = (p == n - 1);
          pairs_due.push_back(pair);
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Pair checker: the block cannot be held off, so take every strobed pair
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pairs_due.size() == 0) begin
        $error("pair for proposer %0d with none expected", result.proposer);
        mismatches++;
      end else begin
        want = pairs_due.pop_front();
        if (result.proposer !== want.proposer) begin
          $error("proposer: expected %0d, got %0d", want.proposer, result.proposer);
          mismatches++;
        end
        if (result.acceptor !== want.acceptor) begin
          $error("acceptor: expected %0d, got %0d", want.acceptor, result.acceptor);
          mismatches++;
        end
        if (result.matched !== want.matched) begin
          $error("matched: expected %0d, got %0d", want.matched, result.matched);
          mismatches++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Driving
  // ------------------------------------------------------------------------
  function automatic in_item_t make_beat(input logic [1:0] cmd, input int person,
                                         input int position, input int partner);
    in_item_t it;
    it.cmd      = cmd;
    it.person   = IDX_W'(person);
    it.position = IDX_W'(position);
    it.partner  = IDX_W'(partner);
    return it;
  endfunction

  // Mostly no gap or a short one, now and then a long one, and occasional
  // bursts with no gap at all
  task automatic sender_gap();
    int r;
    int gap;
    r   = $urandom_range(0, 199);
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else if (r == 0) begin
      burst_left = $urandom_range(16, 48);
    end else if (r >= 100 && r < 175) begin
      gap = $urandom_range(1, 3);
    end else if (r >= 175 && r < 194) begin
      gap = $urandom_range(4, 12);
    end else if (r >= 194) begin
      gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold start high until the block takes the beat; leave it high so a
  // back-to-back beat needs no second assignment in one step
  task automatic send_beat(input in_item_t it);
    sender_gap();
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    absorb_beat(it);
    if (it.cmd != CMD_SPARE) beats_sent++;
  endtask

  task automatic load_pref(input int person, input int position, input int partner);
    send_beat(make_beat(CMD_PREF, person, position, partner));
  endtask

  task automatic load_rank(input int acceptor, input int rank, input int proposer);
    send_beat(make_beat(CMD_RANK, acceptor, rank, proposer));
  endtask

  // Drop start, wait for every pair and for the block to settle
  task automatic drain_pairs();
    start <= 1'b0;
    @(posedge clk);
    while (pairs_due.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_participants(input int value);
    drain_pairs();
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    participants = CNT_W'(value);
  endtask

  function automatic int pick_value(input int n);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, n - 1);
    return $urandom_range(0, MAX_PART - 1);
  endfunction

  // Load any entry the coming solve would read but that holds no data yet,
  // then issue the solve beat with random filler fields
  task automatic solve_and_check();
    int n;
    int hole;
    n    = active_count();
    hole = gale_shapley(n);
    while (hole >= 0) begin
      if (hole < RANK_BASE) begin
        load_pref(hole / MAX_PART, hole % MAX_PART, pick_value(n));
      end else begin
        load_rank((hole - RANK_BASE) / MAX_PART, pick_value(n),
                  (hole - RANK_BASE) % MAX_PART);
      end
      hole = gale_shapley(n);
    end
    send_beat(make_beat(CMD_SOLVE, $urandom_range(0, MAX_PART - 1),
                        $urandom_range(0, MAX_PART - 1), $urandom_range(0, MAX_PART - 1)));
  endtask

  function automatic void shuffle_order(input int n);
    int i;
    int j;
    int t;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = n - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      t        = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endfunction

  // Spare command beats and stray loads anywhere in the tables
  task automatic maybe_noise();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_beat(make_beat(CMD_SPARE, $urandom_range(0, MAX_PART - 1),
                          $urandom_range(0, MAX_PART - 1), $urandom_range(0, MAX_PART - 1)));
    end else if (r < 8) begin
      send_beat(make_beat(r[0] ? CMD_PREF : CMD_RANK, $urandom_range(0, MAX_PART - 1),
                          $urandom_range(0, MAX_PART - 1), $urandom_range(0, MAX_PART - 1)));
    end
  endtask

  task automatic mutate_entry(input int n);
    if ($urandom_range(0, 1) == 1) begin
      load_pref($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_value(n));
    end else begin
      load_rank($urandom_range(0, n - 1), pick_value(n), $urandom_range(0, n - 1));
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // A count of 0 acts as one participant
  task automatic test_single_participant();
    write_participants(0);
    load_pref(0, 0, 0);
    solve_and_check();
  endtask

  // Both propose to acceptor 1, who prefers proposer 1; proposer 0 moves on
  task automatic test_contested_proposal();
    write_participants(2);
    load_pref(0, 0, 1);
    load_pref(1, 0, 1);
    load_pref(0, 1, 0);
    load_pref(1, 1, 0);
    load_rank(1, 0, 1);
    load_rank(1, 1, 0);
    solve_and_check();
  endtask

  // Equal ranks: she keeps whoever reached her first
  task automatic test_equal_ranks();
    load_rank(1, 0, 0);
    solve_and_check();
  endtask

  // Proposer 1 lists acceptor 1 twice and is turned down both times
  task automatic test_list_exhausted();
    load_pref(1, 1, 1);
    solve_and_check();
  endtask

  // A partner index above the participant count is used as it stands
  task automatic test_partner_out_of_range();
    load_pref(0, 0, MAX_PART - 1);
    solve_and_check();
  endtask

  // All-ones fields, stored beyond the count, and an ignored spare command
  task automatic test_field_extremes();
    load_pref(MAX_PART - 1, MAX_PART - 1, MAX_PART - 1);
    load_rank(MAX_PART - 1, MAX_PART - 1, MAX_PART - 1);
    send_beat(make_beat(CMD_SPARE, MAX_PART - 1, MAX_PART - 1, MAX_PART - 1));
    solve_and_check();
  endtask

  // Counts above the maximum clamp to it; then the maximum itself. Give
  // every proposer a distinct first choice so the tables stay small.
  task automatic test_full_size();
    int k;
    write_participants(CFG_TOP);
    shuffle_order(MAX_PART);
    for (k = 0; k < MAX_PART; k++) load_pref(k, 0, order[k]);
    solve_and_check();
    write_participants(MAX_PART);
    for (k = 0; k < 4; k++) mutate_entry(MAX_PART);
    solve_and_check();
  endtask

  // Phases under random counts: mostly whole permutation tables, the rest
  // scattered loads; one to three solves per phase with edits between
  task automatic test_random_phases();
    int base;
    int r;
    int n;
    int p;
    int j;
    int s;
    int solves;
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        write_participants(0);
      end else if (r < 10) begin
        write_participants($urandom_range(MAX_PART + 1, CFG_TOP));
      end else if (r < 85) begin
        write_participants($urandom_range(1, 8));
      end else begin
        write_participants($urandom_range(9, 16));
      end
      n = active_count();
      if (n <= 8 && $urandom_range(0, 99) < 70) begin
        for (p = 0; p < n; p++) begin
          shuffle_order(n);
          for (j = 0; j < n; j++) begin
            maybe_noise();
            load_pref(p, j, order[j]);
          end
        end
        for (p = 0; p < n; p++) begin
          shuffle_order(n);
          for (j = 0; j < n; j++) begin
            maybe_noise();
            load_rank(p, order[j], j);
          end
        end
      end else begin
        for (j = $urandom_range(1, 10); j > 0; j--) begin
          if ($urandom_range(0, 1) == 1) begin
            maybe_noise();
            mutate_entry(n);
          end else begin
            send_beat(make_beat(j[0] ? CMD_PREF : CMD_RANK, $urandom_range(0, MAX_PART - 1),
                                $urandom_range(0, MAX_PART - 1),
                                $urandom_range(0, MAX_PART - 1)));
          end
        end
      end
      solves = $urandom_range(1, 3);
      for (s = 0; s < solves; s++) begin
        // Now and then hold the next beat until every pair is out
        if ($urandom_range(0, 3) == 0) drain_pairs();
        solve_and_check();
        for (j = $urandom_range(0, 2); j > 0; j--) mutate_entry(n);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_single_participant();
    test_contested_proposal();
    test_equal_ranks();
    test_list_exhausted();
    test_partner_out_of_range();
    test_field_extremes();
    test_full_size();
    test_random_phases();
    drain_pairs();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
